[rtl/bitmap_shape_rasterizer_unit_assert.svh]
// Assertion macros for the rasterizer checker.
`ifndef BITMAP_SHAPE_RASTERIZER_UNIT_ASSERT_SVH
`define BITMAP_SHAPE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define BSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsr check failed");

// next-cycle implication
`define BSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsr check failed");

`endif

[rtl/bsr_pkg.sv]
package bsr_pkg;

  localparam int CanvasRowsDef = 30;
  localparam int CanvasColsDef = 60;
  localparam int CircleSteps   = 360;
  localparam int RowBitsW      = 60;
  localparam int CoordW        = 13;

  localparam logic [63:0] PiQ30 = 64'd3373259426;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_LINE   = 3'd1,
    CMD_RECT   = 3'd2,
    CMD_TRI    = 3'd3,
    CMD_CIRCLE = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [16:0] sin_tab_t [91];

  // quarter-wave sine in Q1.16, integer Taylor series in Q2.30
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    logic [63:0] x;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] usum;
    int d;
    int k;
    for (d = 0; d <= 90; d++) begin
      x = (64'(d) * PiQ30) / 64'd180;
      term = x;
      sum = $signed(x);
      for (k = 1; k <= 10; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) sum = sum - $signed(term);
        else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 64'sd0;
      usum = $unsigned(sum) + 64'd8192;
      t[d] = 17'(usum >> 14);
    end
    return t;
  endfunction

  localparam sin_tab_t SinTab = build_sin_tab();

endpackage

[rtl/bitmap_shape_rasterizer_unit.sv]
// Bitmap shape rasterizer: a CANVAS_ROWS x CANVAS_COLS one-bit canvas.
// Command port: a word is taken when start is high and busy is low. command_i
// picks clear, line, rectangle, triangle, circle or read row; the other fields
// carry coordinates and sizes. Codes 6 and 7 are dropped.
// Result port: a read row command returns row_bits_o in the cycle after it is
// taken, marked by valid_o for exactly one cycle. The receiver cannot stall.
// Clear and read keep busy low. A line, rectangle or triangle runs a
// Bresenham stepper that plots one pixel per cycle after a setup state per
// segment. A circle runs 360 points through one shared 10x17 multiplier,
// each point passing through a cosine product, a sine product and a plot
// state. Busy stays high for the whole draw. Off-canvas pixels are dropped.
// Zero sizes draw nothing and leave busy low.
// Reset clears every pixel at once and leaves the block idle.
module bitmap_shape_rasterizer_unit #(
  parameter int CANVAS_ROWS = bsr_pkg::CanvasRowsDef,
  parameter int CANVAS_COLS = bsr_pkg::CanvasColsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [10:0] first_x_i,
  input  logic [10:0] first_y_i,
  input  logic [10:0] second_x_i,
  input  logic [10:0] second_y_i,
  input  logic [9:0]  width_i,
  input  logic [9:0]  height_i,
  input  logic [9:0]  radius_i,
  input  logic [4:0]  read_row_i,
  output logic        valid_o,
  output logic [bsr_pkg::RowBitsW-1:0] row_bits_o
);
  import bsr_pkg::*;

  localparam int RowW = (CANVAS_ROWS > 1) ? $clog2(CANVAS_ROWS) : 1;
  localparam int ColW = (CANVAS_COLS > 1) ? $clog2(CANVAS_COLS) : 1;
  localparam int OutW = (CANVAS_COLS < RowBitsW) ? CANVAS_COLS : RowBitsW;
  localparam int ErrW = 15;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEG_SETUP, ST_SEG_RUN, ST_CIR_COS, ST_CIR_SIN, ST_CIR_PLOT
  } state_e;

  state_e state_q;
  cmd_e   cmd_q;
  logic [1:0] seg_q;
  coord_t x1_q, y1_q, x2_q, y2_q, xl_q;
  coord_t xa_q, ya_q, xb_q, yb_q;
  logic signed [ErrW-1:0] dx_q, dy_q, err_q;
  logic sx_q, sy_q;
  logic [9:0] r_q;
  logic [8:0] angle_q;
  logic [26:0] prod_q;
  logic neg_q;
  coord_t offx_q;
  logic [CANVAS_COLS-1:0] canvas_q [CANVAS_ROWS];
  logic [RowBitsW-1:0] row_bits_d;

  logic accept;
  cmd_e cmd_in;
  coord_t fx, fy, sxi, syi;
  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign cmd_in = cmd_e'(command_i);
  assign fx  = {{2{first_x_i[10]}}, first_x_i};
  assign fy  = {{2{first_y_i[10]}}, first_y_i};
  assign sxi = {{2{second_x_i[10]}}, second_x_i};
  assign syi = {{2{second_y_i[10]}}, second_y_i};

  // segment endpoints
  coord_t s_xa, s_ya, s_xb, s_yb;
  logic last_seg;
  always_comb begin
    s_xa = x1_q; s_ya = y1_q; s_xb = x2_q; s_yb = y2_q;
    last_seg = 1'b1;
    unique case (cmd_q)
      CMD_RECT: begin
        last_seg = (seg_q == 2'd3);
        unique case (seg_q)
          2'd0: begin s_xa = x1_q; s_ya = y1_q; s_xb = x2_q; s_yb = y1_q; end
          2'd1: begin s_xa = x1_q; s_ya = y2_q; s_xb = x2_q; s_yb = y2_q; end
          2'd2: begin s_xa = x1_q; s_ya = y1_q; s_xb = x1_q; s_yb = y2_q; end
          default: begin s_xa = x2_q; s_ya = y1_q; s_xb = x2_q; s_yb = y2_q; end
        endcase
      end
      CMD_TRI: begin
        last_seg = (seg_q == 2'd2);
        unique case (seg_q)
          2'd0: begin s_xa = x1_q; s_ya = y1_q; s_xb = xl_q; s_yb = y2_q; end
          2'd1: begin s_xa = x1_q; s_ya = y1_q; s_xb = x2_q; s_yb = y2_q; end
          default: begin s_xa = xl_q; s_ya = y2_q; s_xb = x2_q; s_yb = y2_q; end
        endcase
      end
      default: ;
    endcase
  end

  logic signed [ErrW-1:0] s_dx, s_dy, e2, err_d;
  logic step_x, step_y;
  always_comb begin
    s_dx = (s_xb > s_xa) ? ErrW'(s_xb - s_xa) : ErrW'(s_xa - s_xb);
    s_dy = (s_yb > s_ya) ? ErrW'(s_yb - s_ya) : ErrW'(s_ya - s_yb);
    e2 = err_q <<< 1;
    step_x = (e2 > -dy_q);
    step_y = (e2 < dx_q);
    err_d = err_q - (step_x ? dy_q : '0) + (step_y ? dx_q : '0);
  end

  // circle: angle to quarter-table index
  logic [8:0] ang;
  logic [9:0] ang_sum;
  logic [6:0] tab_idx;
  logic tab_neg;
  always_comb begin
    ang_sum = (state_q == ST_CIR_COS) ? ({1'b0, angle_q} + 10'd90) : {1'b0, angle_q};
    ang = (ang_sum >= 10'(CircleSteps)) ? 9'(ang_sum - 10'(CircleSteps)) : ang_sum[8:0];
    priority if (ang <= 9'd90) begin
      tab_idx = ang[6:0]; tab_neg = 1'b0;
    end else if (ang <= 9'd180) begin
      tab_idx = 7'(9'd180 - ang); tab_neg = 1'b0;
    end else if (ang <= 9'd270) begin
      tab_idx = 7'(ang - 9'd180); tab_neg = 1'b1;
    end else begin
      tab_idx = 7'(9'd360 - ang); tab_neg = 1'b1;
    end
  end

  logic [26:0] prod_d;
  logic [10:0] rnd_x;
  logic [9:0]  rnd_y;
  coord_t offx_d, offy;
  assign prod_d = 27'(r_q) * 27'(SinTab[tab_idx]);
  assign rnd_x  = 11'((prod_q + 27'd32768) >> 16);
  assign rnd_y  = 10'((prod_q + 27'd65536) >> 17);
  assign offx_d = neg_q ? -coord_t'(rnd_x) : coord_t'(rnd_x);
  assign offy   = neg_q ? -coord_t'(rnd_y) : coord_t'(rnd_y);

  // plot port
  logic plot_en, plot_ok;
  coord_t plot_row, plot_col;
  always_comb begin
    plot_en = 1'b0;
    plot_row = ya_q;
    plot_col = xa_q;
    if (state_q == ST_SEG_RUN) begin
      plot_en = 1'b1;
    end else if (state_q == ST_CIR_PLOT) begin
      plot_en = 1'b1;
      plot_row = y1_q + offy;
      plot_col = x1_q + offx_q;
    end
    plot_ok = plot_en && (plot_row >= 0) && (plot_row < $signed(CoordW'(CANVAS_ROWS)))
              && (plot_col >= 0) && (plot_col < $signed(CoordW'(CANVAS_COLS)));
  end

  logic [6:0] rr_ext;
  logic [CANVAS_COLS-1:0] rd_row;
  assign rr_ext = 7'(read_row_i);
  always_comb begin
    rd_row = (rr_ext < 7'(CANVAS_ROWS)) ? canvas_q[rr_ext[RowW-1:0]] : '0;
    row_bits_d = '0;
    row_bits_d[OutW-1:0] = rd_row[OutW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CANVAS_ROWS; i++) canvas_q[i] <= '0;
    end else if (accept && cmd_in == CMD_CLEAR) begin
      for (int i = 0; i < CANVAS_ROWS; i++) canvas_q[i] <= '0;
    end else if (plot_ok) begin
      canvas_q[plot_row[RowW-1:0]][plot_col[ColW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_o <= 1'b0;
      row_bits_o <= '0;
    end else begin
      valid_o <= accept && (cmd_in == CMD_READ);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            seg_q <= 2'd0;
            angle_q <= '0;
            cmd_q <= cmd_in;
            r_q <= radius_i;
            x1_q <= fx;
            y1_q <= fy;
            xl_q <= fx - coord_t'(height_i) + coord_t'(1);
            unique case (cmd_in)
              CMD_LINE: begin
                x2_q <= sxi;
                y2_q <= syi;
                state_q <= ST_SEG_SETUP;
              end
              CMD_RECT: begin
                x2_q <= fx + coord_t'(width_i) - coord_t'(1);
                y2_q <= fy + coord_t'(height_i) - coord_t'(1);
                if (width_i != '0 && height_i != '0) state_q <= ST_SEG_SETUP;
              end
              CMD_TRI: begin
                x2_q <= fx + coord_t'(height_i) - coord_t'(1);
                y2_q <= fy + coord_t'(height_i) - coord_t'(1);
                if (height_i != '0) state_q <= ST_SEG_SETUP;
              end
              CMD_CIRCLE: if (radius_i != '0) state_q <= ST_CIR_COS;
              CMD_READ: row_bits_o <= row_bits_d;
              default: ;
            endcase
          end
        end
        ST_SEG_SETUP: begin
          xa_q <= s_xa; ya_q <= s_ya; xb_q <= s_xb; yb_q <= s_yb;
          dx_q <= s_dx; dy_q <= s_dy;
          err_q <= s_dx - s_dy;
          sx_q <= (s_xa < s_xb);
          sy_q <= (s_ya < s_yb);
          state_q <= ST_SEG_RUN;
        end
        ST_SEG_RUN: begin
          if (xa_q == xb_q && ya_q == yb_q) begin
            seg_q <= seg_q + 2'd1;
            state_q <= last_seg ? ST_IDLE : ST_SEG_SETUP;
          end else begin
            err_q <= err_d;
            if (step_x) xa_q <= sx_q ? xa_q + coord_t'(1) : xa_q - coord_t'(1);
            if (step_y) ya_q <= sy_q ? ya_q + coord_t'(1) : ya_q - coord_t'(1);
          end
        end
        ST_CIR_COS: begin
          prod_q <= prod_d;
          neg_q <= tab_neg;
          state_q <= ST_CIR_SIN;
        end
        ST_CIR_SIN: begin
          offx_q <= offx_d;
          prod_q <= prod_d;
          neg_q <= tab_neg;
          state_q <= ST_CIR_PLOT;
        end
        ST_CIR_PLOT: begin
          angle_q <= angle_q + 9'd1;
          state_q <= (angle_q == 9'(CircleSteps - 1)) ? ST_IDLE : ST_CIR_COS;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/bsr_checker.sv]
`include "bitmap_shape_rasterizer_unit_assert.svh"

module bsr_checker #(
  parameter int CANVAS_ROWS = bsr_pkg::CanvasRowsDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  command_i,
  input logic [4:0]  read_row_i,
  input logic        valid_o,
  input logic [bsr_pkg::RowBitsW-1:0] row_bits_o
);
  import bsr_pkg::*;

  logic rd_acc;
  assign rd_acc = start && !busy && (command_i == CMD_READ);

  `BSR_ASSERT_NEXT(a_read_gives_word, rd_acc, valid_o)
  `BSR_ASSERT_NOW(a_word_from_read, valid_o, $past(rd_acc))
  `BSR_ASSERT_NEXT(a_read_stays_ready, rd_acc, !busy)
  `BSR_ASSERT_NEXT(a_far_row_zero, rd_acc && (7'(read_row_i) >= 7'(CANVAS_ROWS)), row_bits_o == '0)

endmodule

bind bitmap_shape_rasterizer_unit bsr_checker #(.CANVAS_ROWS(CANVAS_ROWS)) u_bsr_checker (.*);
